// ===== hw/rtl/hpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// hpsd_pkg
// Shared widths, codes and the control store of the H-bridge slew driver.
// ----------------------------------------------------------------------------
`default_nettype none

package hpsd_pkg;

	localparam int DUTY_WIDTH_DEF = 16;
	localparam int MAG_W          = 15;
	localparam int CMD_W          = 16;
	localparam int TIME_W         = 32;
	localparam int OUT_W          = 16;
	localparam int CODE_W         = 2;
	localparam int STEP_W         = 4;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 32;
	localparam int DIV_RADIX      = 4;

	localparam logic [MAG_W-1:0]  DEFAULT_MAX     = MAG_W'(1000);
	localparam logic [MAG_W-1:0]  RST_SLEW        = MAG_W'(1000);
	localparam logic [OUT_W-1:0]  RST_PERIOD_TOP  = {OUT_W{1'b1}};

	typedef enum logic [CODE_W-1:0] {
		CMD_SET    = 2'd0,
		CMD_STOP   = 2'd1,
		CMD_FORCE  = 2'd2,
		CMD_UPDATE = 2'd3
	} cmd_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_COMMAND = 3'd0,
		REG_SLEW_STEP   = 3'd1,
		REG_DEAD_BAND   = 3'd2,
		REG_MIN_START   = 3'd3,
		REG_BRAKE       = 3'd4,
		REG_PERIOD_TOP  = 3'd5,
		REG_TIMEOUT     = 3'd6
	} cfg_reg_t;

	typedef enum logic [3:0] {
		OP_NOP     = 4'd0,
		OP_LOAD    = 4'd1,
		OP_TIMEOUT = 4'd2,
		OP_DIFF    = 4'd3,
		OP_SLEW    = 4'd4,
		OP_SET     = 4'd5,
		OP_STOP    = 4'd6,
		OP_FORCE   = 4'd7,
		OP_MAG     = 4'd8,
		OP_MUL     = 4'd9,
		OP_DIV     = 4'd10,
		OP_RESULT  = 4'd11
	} op_t;

	typedef enum logic [3:0] {
		CJ_NEVER    = 4'd0,
		CJ_ALWAYS   = 4'd1,
		CJ_NO_XFER  = 4'd2,
		CJ_IS_SET   = 4'd3,
		CJ_IS_STOP  = 4'd4,
		CJ_IS_FORCE = 4'd5,
		CJ_SKIP_DIV = 4'd6,
		CJ_DIV_MORE = 4'd7,
		CJ_OUT_FREE = 4'd8
	} cond_t;

	localparam logic [STEP_W-1:0] ST_WAIT     = 4'd0;
	localparam logic [STEP_W-1:0] ST_DSP_SET  = 4'd1;
	localparam logic [STEP_W-1:0] ST_DSP_STOP = 4'd2;
	localparam logic [STEP_W-1:0] ST_DSP_FRC  = 4'd3;
	localparam logic [STEP_W-1:0] ST_TIMEOUT  = 4'd4;
	localparam logic [STEP_W-1:0] ST_DIFF     = 4'd5;
	localparam logic [STEP_W-1:0] ST_SLEW     = 4'd6;
	localparam logic [STEP_W-1:0] ST_SET      = 4'd7;
	localparam logic [STEP_W-1:0] ST_STOP     = 4'd8;
	localparam logic [STEP_W-1:0] ST_FORCE    = 4'd9;
	localparam logic [STEP_W-1:0] ST_MAG      = 4'd10;
	localparam logic [STEP_W-1:0] ST_MUL      = 4'd11;
	localparam logic [STEP_W-1:0] ST_DIV      = 4'd12;
	localparam logic [STEP_W-1:0] ST_OUT      = 4'd13;
	localparam logic [STEP_W-1:0] ST_OUT_HOLD = 4'd14;
	localparam logic [STEP_W-1:0] ST_SPARE    = 4'd15;

	typedef struct packed {
		op_t                op;
		cond_t              cond;
		logic [STEP_W-1:0]  target;
	} uword_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

	// control store: jump to target when cond holds, else fall through
	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		case (step)
			ST_WAIT:     w = '{OP_LOAD,    CJ_NO_XFER,  ST_WAIT};
			ST_DSP_SET:  w = '{OP_NOP,     CJ_IS_SET,   ST_SET};
			ST_DSP_STOP: w = '{OP_NOP,     CJ_IS_STOP,  ST_STOP};
			ST_DSP_FRC:  w = '{OP_NOP,     CJ_IS_FORCE, ST_FORCE};
			ST_TIMEOUT:  w = '{OP_TIMEOUT, CJ_NEVER,    ST_WAIT};
			ST_DIFF:     w = '{OP_DIFF,    CJ_NEVER,    ST_WAIT};
			ST_SLEW:     w = '{OP_SLEW,    CJ_ALWAYS,   ST_MAG};
			ST_SET:      w = '{OP_SET,     CJ_ALWAYS,   ST_WAIT};
			ST_STOP:     w = '{OP_STOP,    CJ_ALWAYS,   ST_MAG};
			ST_FORCE:    w = '{OP_FORCE,   CJ_NEVER,    ST_WAIT};
			ST_MAG:      w = '{OP_MAG,     CJ_NEVER,    ST_WAIT};
			ST_MUL:      w = '{OP_MUL,     CJ_SKIP_DIV, ST_OUT};
			ST_DIV:      w = '{OP_DIV,     CJ_DIV_MORE, ST_DIV};
			ST_OUT:      w = '{OP_RESULT,  CJ_OUT_FREE, ST_WAIT};
			ST_OUT_HOLD: w = '{OP_NOP,     CJ_ALWAYS,   ST_OUT};
			default:     w = '{OP_NOP,     CJ_ALWAYS,   ST_WAIT};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hpsd_if.sv =====
// ----------------------------------------------------------------------------
// hpsd_if
// Valid/ready channels of the H-bridge slew driver: command in, duty out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpsd_cmd_if import hpsd_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [CODE_W-1:0]        command;
	logic signed [CMD_W-1:0]  cmd_value;
	logic [TIME_W-1:0]        time_ms;

	modport source (output valid, command, cmd_value, time_ms, input ready);
	modport sink   (input valid, command, cmd_value, time_ms, output ready);
endinterface

interface hpsd_duty_if import hpsd_pkg::*;;
	logic               valid;
	logic               ready;
	logic [OUT_W-1:0]   duty_in1;
	logic [OUT_W-1:0]   duty_in2;

	modport source (output valid, duty_in1, duty_in2, input ready);
	modport sink   (input valid, duty_in1, duty_in2, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hbridge_pwm_slew_driver_core.sv =====
// ----------------------------------------------------------------------------
// hbridge_pwm_slew_driver_core
// H-bridge PWM compare values from a signed speed command, with slew limit,
// command timeout, deadband, minimum start and brake/coast at zero.
//
//   channel  dir  payload                          transfer
//   cmd      in   command, cmd_value, time_ms      valid && ready
//   duty     out  duty_in1, duty_in2               valid && ready
//   cfg      in   cfg_index, cfg_data              cfg_wr_en
//
// one item at a time, stepped by a microcoded sequencer; ready only at step 0
// set returns to fetch after its set step; stop, force and update go on to the
// magnitude step (update first runs the timeout, diff and slew steps), and a
// nonzero, non-full magnitude is scaled by the multiply and the radix-16 divide loop
// a finished result sits in the output register; the next item waits only
// when a second result is ready before the first is taken
// reset clears configuration, state and control to defaults; payload registers are not reset; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module hbridge_pwm_slew_driver_core import hpsd_pkg::*; #(
	parameter int DUTY_WIDTH = DUTY_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	hpsd_cmd_if.sink                    cmd,
	hpsd_duty_if.source                 duty,
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	// configuration
	logic [MAG_W-1:0]  max_q;
	logic [MAG_W-1:0]  slew_q;
	logic [MAG_W-1:0]  db_q;
	logic [MAG_W-1:0]  ms_q;
	logic              brake_q;
	logic [OUT_W-1:0]  top_q;
	logic [TIME_W-1:0] tmo_q;

	// state
	logic signed [CMD_W-1:0] target_q;
	logic signed [CMD_W-1:0] current_q;
	logic [TIME_W-1:0]       last_q;

	// sequencer and datapath
	logic [STEP_W-1:0]       step_q;
	logic [CODE_W-1:0]       code_q;
	logic signed [CMD_W-1:0] val_q;
	logic [TIME_W-1:0]       time_q;
	logic signed [CMD_W-1:0] diff_q;
	logic [MAG_W-1:0]        mag_q;
	logic                    neg_q;
	logic                    zero_q;
	logic                    full_q;
	logic                    duty_valid_q;
	logic [OUT_W-1:0]        duty1_q;
	logic [OUT_W-1:0]        duty2_q;

	uword_t                  uw;
	logic                    in_xfer;
	logic                    jump;
	div_ctrl_t               div_ctrl;
	logic                    div_last;
	logic [DUTY_WIDTH-1:0]   quotient;

	logic [MAG_W-1:0]        m_eff;
	logic [MAG_W-1:0]        step_eff;
	logic [MAG_W-1:0]        db_eff;
	logic [MAG_W-1:0]        ms_eff;
	logic [DUTY_WIDTH-1:0]   top_eff;
	logic signed [CMD_W-1:0] val_clamp;
	logic signed [CMD_W-1:0] diff_clamp;
	logic                    timed_out;
	logic [MAG_W-1:0]        mag_nxt;
	logic [DUTY_WIDTH-1:0]   ccr;
	logic [DUTY_WIDTH-1:0]   zero_duty;

	assign m_eff    = (max_q == '0) ? DEFAULT_MAX : max_q;
	assign step_eff = (slew_q == '0) ? m_eff : slew_q;
	assign db_eff   = (db_q > m_eff) ? m_eff : db_q;
	assign ms_eff   = (ms_q > m_eff) ? m_eff : ms_q;
	assign top_eff  = top_q[DUTY_WIDTH-1:0];

	always_comb begin : clamp_value
		logic signed [CMD_W:0] v;
		logic signed [CMD_W:0] mx;
		v  = {val_q[CMD_W-1], val_q};
		mx = signed'({2'b00, m_eff});
		if (v > mx) begin
			val_clamp = mx[CMD_W-1:0];
		end else if (v < -mx) begin
			val_clamp = CMD_W'(-mx);
		end else begin
			val_clamp = val_q;
		end
	end

	always_comb begin : clamp_diff
		logic signed [CMD_W:0] d;
		logic signed [CMD_W:0] sx;
		d  = {target_q[CMD_W-1], target_q} - {current_q[CMD_W-1], current_q};
		sx = signed'({2'b00, step_eff});
		if (d > sx) begin
			diff_clamp = sx[CMD_W-1:0];
		end else if (d < -sx) begin
			diff_clamp = CMD_W'(-sx);
		end else begin
			diff_clamp = d[CMD_W-1:0];
		end
	end

	assign timed_out = (tmo_q != '0) && ((time_q - last_q) > tmo_q);

	always_comb begin : magnitude
		logic [CMD_W-1:0] a;
		logic [MAG_W-1:0] ma;
		a  = current_q[CMD_W-1] ? CMD_W'(-current_q) : CMD_W'(current_q);
		ma = (a[MAG_W-1:0] <= db_eff) ? '0 : a[MAG_W-1:0];
		mag_nxt = ((ma != '0) && (ma < ms_eff)) ? ms_eff : ma;
	end

	assign zero_duty = brake_q ? top_eff : '0;
	assign ccr       = full_q ? top_eff : quotient;

	// sequencer
	assign uw        = ucode(step_q);
	assign cmd.ready = (step_q == ST_WAIT);
	assign in_xfer   = cmd.valid && cmd.ready;

	always_comb begin
		case (uw.cond)
			CJ_NEVER:    jump = 1'b0;
			CJ_ALWAYS:   jump = 1'b1;
			CJ_NO_XFER:  jump = !in_xfer;
			CJ_IS_SET:   jump = (code_q == CMD_SET);
			CJ_IS_STOP:  jump = (code_q == CMD_STOP);
			CJ_IS_FORCE: jump = (code_q == CMD_FORCE);
			CJ_SKIP_DIV: jump = zero_q || full_q;
			CJ_DIV_MORE: jump = !div_last;
			CJ_OUT_FREE: jump = !duty_valid_q;
			default:     jump = 1'b1;
		endcase
	end

	assign div_ctrl = '{load: (uw.op == OP_MUL), step: (uw.op == OP_DIV)};

	hpsd_muldiv #(
		.DUTY_WIDTH (DUTY_WIDTH)
	) u_muldiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.mag      (mag_q),
		.top      (top_eff),
		.divisor  (m_eff),
		.last     (div_last),
		.quotient (quotient)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= DEFAULT_MAX;
			slew_q  <= RST_SLEW;
			db_q    <= '0;
			ms_q    <= '0;
			brake_q <= 1'b0;
			top_q   <= RST_PERIOD_TOP;
			tmo_q   <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MAX_COMMAND: max_q   <= cfg_data[MAG_W-1:0];
				REG_SLEW_STEP:   slew_q  <= cfg_data[MAG_W-1:0];
				REG_DEAD_BAND:   db_q    <= cfg_data[MAG_W-1:0];
				REG_MIN_START:   ms_q    <= cfg_data[MAG_W-1:0];
				REG_BRAKE:       brake_q <= cfg_data[0];
				REG_PERIOD_TOP:  top_q   <= cfg_data[OUT_W-1:0];
				REG_TIMEOUT:     tmo_q   <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= ST_WAIT;
			target_q     <= '0;
			current_q    <= '0;
			last_q       <= '0;
			duty_valid_q <= 1'b0;
		end else begin
			step_q <= jump ? uw.target : step_q + STEP_W'(1);
			if (duty.valid && duty.ready) begin
				duty_valid_q <= 1'b0;
			end
			case (uw.op)
				OP_TIMEOUT: begin
					if (timed_out) begin
						target_q <= '0;
					end
				end
				OP_SLEW:   current_q <= current_q + diff_q;
				OP_SET: begin
					target_q <= val_clamp;
					last_q   <= time_q;
				end
				OP_STOP: begin
					target_q  <= '0;
					current_q <= '0;
				end
				OP_FORCE: begin
					target_q  <= val_clamp;
					current_q <= val_clamp;
				end
				OP_RESULT: begin
					if (!duty_valid_q) begin
						duty_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (uw.op)
			OP_LOAD: begin
				if (in_xfer) begin
					code_q <= cmd.command;
					val_q  <= cmd.cmd_value;
					time_q <= cmd.time_ms;
				end
			end
			OP_DIFF: diff_q <= diff_clamp;
			OP_MAG: begin
				mag_q  <= mag_nxt;
				neg_q  <= current_q[CMD_W-1];
				zero_q <= (mag_nxt == '0);
				full_q <= (mag_nxt >= m_eff);
			end
			OP_RESULT: begin
				if (!duty_valid_q) begin
					duty1_q <= OUT_W'(zero_q ? zero_duty : (neg_q ? '0 : ccr));
					duty2_q <= OUT_W'(zero_q ? zero_duty : (neg_q ? ccr : '0));
				end
			end
			default: ;
		endcase
	end

	assign duty.valid    = duty_valid_q;
	assign duty.duty_in1 = duty1_q;
	assign duty.duty_in2 = duty2_q;

	// a new result appears only out of the result step
	a_result_from_out_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(duty_valid_q) |-> $past(step_q) == ST_OUT)
		else $error("result raised outside the result step");

	// set transfers return to the fetch step
	a_set_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && cmd.command == CMD_SET) |-> ##3 (step_q == ST_WAIT))
		else $error("set command did not return to fetch");

	// the spare control word is never reached
	a_no_spare_step: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != ST_SPARE)
		else $error("sequencer reached the spare step");

	// divide loop is entered only from the multiply step
	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_DIV && $past(step_q) != ST_DIV) |-> $past(step_q) == ST_MUL)
		else $error("divide loop entered out of sequence");

endmodule

`default_nettype wire

// ===== hw/rtl/hpsd_muldiv.sv =====
// ----------------------------------------------------------------------------
// hpsd_muldiv
// Duty scaling mag*top/max: one product at load, then restoring division
// retiring DIV_RADIX quotient bits per step.
// ----------------------------------------------------------------------------
`default_nettype none

module hpsd_muldiv import hpsd_pkg::*; #(
	parameter int DUTY_WIDTH = DUTY_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire div_ctrl_t              ctrl,
	input  wire logic [MAG_W-1:0]       mag,
	input  wire logic [DUTY_WIDTH-1:0]  top,
	input  wire logic [MAG_W-1:0]       divisor,
	output logic                        last,
	output logic [DUTY_WIDTH-1:0]       quotient
);

	localparam int PROD_W = MAG_W + DUTY_WIDTH;
	localparam int ITERS  = (PROD_W + DIV_RADIX - 1) / DIV_RADIX;
	localparam int DIVD_W = ITERS * DIV_RADIX;
	localparam int CNT_W  = $clog2(ITERS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ITERS - 1);

	logic [DIVD_W-1:0] divd_q;
	logic [MAG_W-1:0]  rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVD_W-1:0] divd_nxt;
	logic [MAG_W-1:0]  rem_nxt;

	always_comb begin : radix_step
		logic [MAG_W:0]    trial;
		logic [MAG_W-1:0]  r;
		logic [DIVD_W-1:0] d;
		r = rem_q;
		d = divd_q;
		trial = '0;
		for (int i = 0; i < DIV_RADIX; i++) begin
			trial = {r, d[DIVD_W-1]};
			d = {d[DIVD_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				trial = trial - {1'b0, divisor};
				d[0] = 1'b1;
			end
			r = trial[MAG_W-1:0];
		end
		divd_nxt = d;
		rem_nxt  = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.load) begin
			cnt_q <= '0;
		end else if (ctrl.step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			divd_q <= DIVD_W'(PROD_W'(mag) * PROD_W'(top));
			rem_q  <= '0;
		end else if (ctrl.step) begin
			divd_q <= divd_nxt;
			rem_q  <= rem_nxt;
		end
	end

	assign last     = (cnt_q == CNT_LAST);
	assign quotient = divd_q[DUTY_WIDTH-1:0];

endmodule

`default_nettype wire
